>>> rtl/xpfr_pkg.sv
// ----------------------------------------------------------------------------
// xpfr_pkg
// Shared types, constants and helpers of the XOR parity frame recovery unit.
// ----------------------------------------------------------------------------
package xpfr_pkg;

    localparam int CACHE_SLOTS   = 4096;
    localparam int PAYLOAD_WORDS = 20;
    localparam int WINDOW_HALF   = 32;

    localparam int SLOT_W  = $clog2(CACHE_SLOTS);
    localparam int WADDR_W = $clog2(CACHE_SLOTS * PAYLOAD_WORDS);
    localparam int WIDX_W  = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

    localparam logic [1:0] CMD_FRAME  = 2'd0;
    localparam logic [1:0] CMD_PARITY = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic RES_REPORT = 1'b0;
    localparam logic RES_READ   = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] sequence_req;
        logic [4:0]  word_index;
        logic [63:0] word_data;
        logic        last;
    } xpfr_req_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] window_first;
        logic [63:0] emit_mask;
        logic        emit_top;
        logic [63:0] read_data;
        logic        read_present;
    } xpfr_rsp_t;

    typedef struct packed {
        logic [31:0]              tag;
        logic                     present;
        logic                     emitted;
        logic [PAYLOAD_WORDS-1:0] wmask;
    } fmeta_t;

    typedef struct packed {
        logic [31:0]              tag;
        logic                     present;
        logic [PAYLOAD_WORDS-1:0] wmask;
    } pmeta_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] raddr;
    } slot_port_t;

    typedef struct packed {
        logic               we;
        logic [WADDR_W-1:0] waddr;
        logic [WADDR_W-1:0] raddr;
    } word_port_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_META,
        ST_WR_META,
        ST_RD_WORD,
        ST_RD_REPLY,
        ST_P_RD,
        ST_P_CHK,
        ST_A_CHK,
        ST_B_CHK,
        ST_X_RD,
        ST_X_WR,
        ST_X_META,
        ST_E_RD,
        ST_E_CHK,
        ST_REPORT
    } state_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [31:0] seq);
        return SLOT_W'(seq % CACHE_SLOTS);
    endfunction

    function automatic logic [WADDR_W-1:0] word_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [WIDX_W-1:0] w);
        return WADDR_W'(slot) * WADDR_W'(PAYLOAD_WORDS) + WADDR_W'(w);
    endfunction

    function automatic logic mask_bit(input logic [PAYLOAD_WORDS-1:0] mask,
                                      input logic [5:0] w);
        return |(mask & (PAYLOAD_WORDS'(1) << w));
    endfunction

    function automatic fmeta_t fclaim(input fmeta_t m, input logic [31:0] seq);
        fmeta_t r;
        r = m;
        if (m.tag != seq) begin
            r = '{tag: seq, present: 1'b0, emitted: 1'b0, wmask: '0};
        end
        return r;
    endfunction

    function automatic pmeta_t pclaim(input pmeta_t m, input logic [31:0] seq);
        pmeta_t r;
        r = m;
        if (m.tag != seq) begin
            r = '{tag: seq, present: 1'b0, wmask: '0};
        end
        return r;
    endfunction

endpackage

>>> rtl/xor_parity_frame_recovery_unit.sv
// ----------------------------------------------------------------------------
// xor_parity_frame_recovery_unit
// Frame and parity slot cache with XOR recovery over a window around each
// packet end, reporting emissions as a window mask.
//
//   channel | ports                  | timing
//   --------+------------------------+---------------------------------------
//   in      | start, busy, req       | word taken when start && !busy
//   out     | done, rsp              | one-cycle strobe, cannot be held off
//
// After reset a clearing pass over all CACHE_SLOTS (4096) slots runs with busy high.
// A non-final word passes through RD_META and WR_META; a read through RD_META, RD_WORD and RD_REPLY.
// A packet end runs recovery passes over the window sequences (up to 65),
// with a parity check, frame checks and a word-by-word XOR rebuild of any
// missing frame, repeated until a pass rebuilds nothing, then an emission
// sweep; the one read port of each slot table bounds this. done and rsp come
// together, registered in the cycle after the sequencer's final state.
// ----------------------------------------------------------------------------
module xor_parity_frame_recovery_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  xpfr_pkg::xpfr_req_t req,
    output logic                done,
    output xpfr_pkg::xpfr_rsp_t rsp
);

    import xpfr_pkg::*;

    slot_port_t  fm_port, pm_port;
    word_port_t  fw_port, pw_port;
    fmeta_t      fm_wdata, fm_rdata;
    pmeta_t      pm_wdata, pm_rdata;
    logic [63:0] fw_wdata, fw_rdata, pw_wdata, pw_rdata;
    logic        res_valid;
    xpfr_rsp_t   res;
    logic        done_reg;
    xpfr_rsp_t   rsp_reg;

    xpfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res),
        .fm_port   (fm_port),
        .fm_wdata  (fm_wdata),
        .fm_rdata  (fm_rdata),
        .pm_port   (pm_port),
        .pm_wdata  (pm_wdata),
        .pm_rdata  (pm_rdata),
        .fw_port   (fw_port),
        .fw_wdata  (fw_wdata),
        .fw_rdata  (fw_rdata),
        .pw_port   (pw_port),
        .pw_wdata  (pw_wdata),
        .pw_rdata  (pw_rdata)
    );

    xpfr_ram #(.DEPTH(CACHE_SLOTS), .WIDTH($bits(fmeta_t))) u_fmeta (
        .clk   (clk),
        .we    (fm_port.we),
        .waddr (fm_port.waddr),
        .wdata (fm_wdata),
        .raddr (fm_port.raddr),
        .rdata (fm_rdata)
    );

    xpfr_ram #(.DEPTH(CACHE_SLOTS), .WIDTH($bits(pmeta_t))) u_pmeta (
        .clk   (clk),
        .we    (pm_port.we),
        .waddr (pm_port.waddr),
        .wdata (pm_wdata),
        .raddr (pm_port.raddr),
        .rdata (pm_rdata)
    );

    xpfr_ram #(.DEPTH(CACHE_SLOTS * PAYLOAD_WORDS), .WIDTH(64)) u_fwords (
        .clk   (clk),
        .we    (fw_port.we),
        .waddr (fw_port.waddr),
        .wdata (fw_wdata),
        .raddr (fw_port.raddr),
        .rdata (fw_rdata)
    );

    xpfr_ram #(.DEPTH(CACHE_SLOTS * PAYLOAD_WORDS), .WIDTH(64)) u_pwords (
        .clk   (clk),
        .we    (pw_port.we),
        .waddr (pw_port.waddr),
        .wdata (pw_wdata),
        .raddr (pw_port.raddr),
        .rdata (pw_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> rtl/xpfr_ram.sv
// ----------------------------------------------------------------------------
// xpfr_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module xpfr_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/xpfr_ctrl.sv
// ----------------------------------------------------------------------------
// xpfr_ctrl
// Sequencer: clearing pass, word writes, reads, recovery passes, emission sweep.
// ----------------------------------------------------------------------------
module xpfr_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  xpfr_pkg::xpfr_req_t         req,
    output logic                        busy,
    output logic                        res_valid,
    output xpfr_pkg::xpfr_rsp_t         res,
    output xpfr_pkg::slot_port_t        fm_port,
    output xpfr_pkg::fmeta_t            fm_wdata,
    input  xpfr_pkg::fmeta_t            fm_rdata,
    output xpfr_pkg::slot_port_t        pm_port,
    output xpfr_pkg::pmeta_t            pm_wdata,
    input  xpfr_pkg::pmeta_t            pm_rdata,
    output xpfr_pkg::word_port_t        fw_port,
    output logic [63:0]                 fw_wdata,
    input  logic [63:0]                 fw_rdata,
    output xpfr_pkg::word_port_t        pw_port,
    output logic [63:0]                 pw_wdata,
    input  logic [63:0]                 pw_rdata
);

    import xpfr_pkg::*;

    state_t                   state_reg, state_next;
    xpfr_req_t                req_reg, req_next;
    logic [31:0]              first_reg, first_next;
    logic [31:0]              last_reg, last_next;
    logic [31:0]              cur_reg, cur_next;
    logic                     changed_reg, changed_next;
    logic [63:0]              mask_reg, mask_next;
    logic                     top_reg, top_next;
    pmeta_t                   pmr_reg, pmr_next;
    fmeta_t                   a_reg, a_next;
    fmeta_t                   dst_reg, dst_next;
    logic [SLOT_W-1:0]        dst_slot_reg, dst_slot_next;
    logic [SLOT_W-1:0]        src_slot_reg, src_slot_next;
    logic [PAYLOAD_WORDS-1:0] src_mask_reg, src_mask_next;
    logic [WIDX_W-1:0]        w_reg, w_next;
    logic [SLOT_W-1:0]        clr_reg, clr_next;
    logic                     rd_pres_reg, rd_pres_next;
    logic                     rd_use_reg, rd_use_next;

    logic [31:0]  seq_in;
    logic [31:0]  prev_seq;
    logic [SLOT_W-1:0] req_slot, cur_slot, prev_slot;
    logic         at_end, clr_end, w_last, wi_ok;
    logic         p_hit, fix_a, fix_b;
    fmeta_t       f_cl_req, f_cl_cur, f_cl_prev, f_pkt, f_emit;
    pmeta_t       p_cl_req, p_cl_cur, p_pkt;
    logic [31:0]  win_first;
    logic [32:0]  win_last_wide;
    logic [31:0]  win_last;
    logic [31:0]  off_pkt, off_cur;
    logic         pkt_emit;
    logic [63:0]  x_word;

    // ------------------------------------------------------------------ decode
    always_comb
    begin
        seq_in    = (req.cmd == CMD_PARITY) ? {16'd0, req.sequence_req[15:0]}
                                            : req.sequence_req;
        prev_seq  = cur_reg - 32'd1;
        req_slot  = slot_of(req_reg.sequence_req);
        cur_slot  = slot_of(cur_reg);
        prev_slot = slot_of(prev_seq);
        at_end    = (cur_reg == last_reg);
        clr_end   = (clr_reg == SLOT_W'(CACHE_SLOTS - 1));
        w_last    = (w_reg == WIDX_W'(PAYLOAD_WORDS - 1));
        wi_ok     = (int'(req_reg.word_index) < PAYLOAD_WORDS);

        f_cl_req  = fclaim(fm_rdata, req_reg.sequence_req);
        p_cl_req  = pclaim(pm_rdata, req_reg.sequence_req);
        f_cl_cur  = fclaim(fm_rdata, cur_reg);
        f_cl_prev = fclaim(fm_rdata, prev_seq);
        p_cl_cur  = pclaim(pm_rdata, cur_reg);

        p_hit = p_cl_cur.present;
        fix_a = !a_reg.present && f_cl_prev.present;
        fix_b = !f_cl_prev.present && a_reg.present;

        win_first = (req_reg.sequence_req > 32'(WINDOW_HALF))
                  ? req_reg.sequence_req - 32'(WINDOW_HALF) : 32'd1;
        win_last_wide = {1'b0, req_reg.sequence_req} + 33'(WINDOW_HALF);
        win_last = win_last_wide[32] ? 32'hFFFF_FFFF : win_last_wide[31:0];
        off_pkt  = req_reg.sequence_req - win_first;
        off_cur  = cur_reg - first_reg;

        p_pkt = p_cl_req;
        if (!p_cl_req.present && wi_ok)
        begin
            p_pkt.wmask = p_cl_req.wmask | (PAYLOAD_WORDS'(1) << req_reg.word_index);
        end
        if (req_reg.last)
        begin
            p_pkt.present = 1'b1;
        end

        f_pkt    = f_cl_req;
        pkt_emit = 1'b0;
        if (!f_cl_req.present && wi_ok)
        begin
            f_pkt.wmask = f_cl_req.wmask | (PAYLOAD_WORDS'(1) << req_reg.word_index);
        end
        if (req_reg.last)
        begin
            f_pkt.present = 1'b1;
            if (!f_cl_req.emitted)
            begin
                f_pkt.emitted = 1'b1;
                pkt_emit      = 1'b1;
            end
        end

        f_emit = f_cl_cur;
        if (f_cl_cur.present && !f_cl_cur.emitted)
        begin
            f_emit.emitted = 1'b1;
        end

        x_word = (mask_bit(src_mask_reg, 6'(w_reg)) ? fw_rdata : 64'd0)
               ^ (mask_bit(pmr_reg.wmask, 6'(w_reg)) ? pw_rdata : 64'd0);
    end

    // -------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (clr_end) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (start && req.cmd != 2'd3)
                begin
                    state_next = ST_RD_META;
                end
            end
            ST_RD_META:  state_next = (req_reg.cmd == CMD_READ) ? ST_RD_WORD : ST_WR_META;
            ST_RD_WORD:  state_next = ST_RD_REPLY;
            ST_RD_REPLY: state_next = ST_IDLE;
            ST_WR_META:  state_next = req_reg.last ? ST_P_RD : ST_IDLE;
            ST_P_RD:     state_next = ST_P_CHK;
            ST_P_CHK:
            begin
                if (p_hit)                     state_next = ST_A_CHK;
                else if (at_end && !changed_reg) state_next = ST_E_RD;
                else                           state_next = ST_P_RD;
            end
            ST_A_CHK:    state_next = ST_B_CHK;
            ST_B_CHK:
            begin
                if (fix_a || fix_b)            state_next = ST_X_RD;
                else if (at_end && !changed_reg) state_next = ST_E_RD;
                else                           state_next = ST_P_RD;
            end
            ST_X_RD:     state_next = ST_X_WR;
            ST_X_WR:     state_next = w_last ? ST_X_META : ST_X_RD;
            ST_X_META:   state_next = ST_P_RD;
            ST_E_RD:     state_next = ST_E_CHK;
            ST_E_CHK:    state_next = at_end ? ST_REPORT : ST_E_RD;
            ST_REPORT:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------ outputs
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        res_valid = 1'b0;
        res       = '0;
        fm_port   = '0;
        fm_wdata  = f_cl_cur;
        pm_port   = '0;
        pm_wdata  = p_cl_cur;
        fw_port   = '0;
        fw_wdata  = req_reg.word_data;
        pw_port   = '0;
        pw_wdata  = req_reg.word_data;

        case (state_reg)
            ST_CLEAR:
            begin
                fm_port.we    = 1'b1;
                fm_port.waddr = clr_reg;
                fm_wdata      = '{tag: '1, present: 1'b0, emitted: 1'b0, wmask: '0};
                pm_port.we    = 1'b1;
                pm_port.waddr = clr_reg;
                pm_wdata      = '{tag: '1, present: 1'b0, wmask: '0};
            end
            ST_RD_META:
            begin
                fm_port.raddr = req_slot;
                pm_port.raddr = req_slot;
            end
            ST_RD_WORD:
            begin
                fw_port.raddr = word_addr(req_slot, WIDX_W'(req_reg.word_index));
            end
            ST_RD_REPLY:
            begin
                res_valid        = 1'b1;
                res.result_kind  = RES_READ;
                res.read_data    = rd_use_reg ? fw_rdata : 64'd0;
                res.read_present = rd_pres_reg;
            end
            ST_WR_META:
            begin
                if (req_reg.cmd == CMD_PARITY)
                begin
                    pm_port.we    = 1'b1;
                    pm_port.waddr = req_slot;
                    pm_wdata      = p_pkt;
                    pw_port.we    = !p_cl_req.present && wi_ok;
                    pw_port.waddr = word_addr(req_slot, WIDX_W'(req_reg.word_index));
                end
                else
                begin
                    fm_port.we    = 1'b1;
                    fm_port.waddr = req_slot;
                    fm_wdata      = f_pkt;
                    fw_port.we    = !f_cl_req.present && wi_ok;
                    fw_port.waddr = word_addr(req_slot, WIDX_W'(req_reg.word_index));
                end
            end
            ST_P_RD:
            begin
                pm_port.raddr = cur_slot;
            end
            ST_P_CHK:
            begin
                pm_port.we    = 1'b1;
                pm_port.waddr = cur_slot;
                pm_wdata      = p_cl_cur;
                fm_port.raddr = cur_slot;
            end
            ST_A_CHK:
            begin
                fm_port.we    = 1'b1;
                fm_port.waddr = cur_slot;
                fm_wdata      = f_cl_cur;
                fm_port.raddr = prev_slot;
            end
            ST_B_CHK:
            begin
                fm_port.we    = 1'b1;
                fm_port.waddr = prev_slot;
                fm_wdata      = f_cl_prev;
            end
            ST_X_RD:
            begin
                fw_port.raddr = word_addr(src_slot_reg, w_reg);
                pw_port.raddr = word_addr(cur_slot, w_reg);
            end
            ST_X_WR:
            begin
                fw_port.we    = 1'b1;
                fw_port.waddr = word_addr(dst_slot_reg, w_reg);
                fw_wdata      = x_word;
            end
            ST_X_META:
            begin
                fm_port.we    = 1'b1;
                fm_port.waddr = dst_slot_reg;
                fm_wdata      = dst_reg;
                fm_wdata.present = 1'b1;
                fm_wdata.wmask   = '1;
            end
            ST_E_RD:
            begin
                fm_port.raddr = cur_slot;
            end
            ST_E_CHK:
            begin
                fm_port.we    = 1'b1;
                fm_port.waddr = cur_slot;
                fm_wdata      = f_emit;
            end
            ST_REPORT:
            begin
                res_valid        = 1'b1;
                res.result_kind  = RES_REPORT;
                res.window_first = first_reg;
                res.emit_mask    = mask_reg;
                res.emit_top     = top_reg;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        req_next      = req_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        cur_next      = cur_reg;
        changed_next  = changed_reg;
        mask_next     = mask_reg;
        top_next      = top_reg;
        pmr_next      = pmr_reg;
        a_next        = a_reg;
        dst_next      = dst_reg;
        dst_slot_next = dst_slot_reg;
        src_slot_next = src_slot_reg;
        src_mask_next = src_mask_reg;
        w_next        = w_reg;
        clr_next      = clr_reg;
        rd_pres_next  = rd_pres_reg;
        rd_use_next   = rd_use_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + SLOT_W'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next              = req;
                    req_next.sequence_req = seq_in;
                end
            end
            ST_RD_WORD:
            begin
                rd_pres_next = f_cl_req.present && (fm_rdata.tag == req_reg.sequence_req);
                rd_use_next  = (fm_rdata.tag == req_reg.sequence_req) && fm_rdata.present
                             && wi_ok && mask_bit(fm_rdata.wmask, 6'(req_reg.word_index));
            end
            ST_WR_META:
            begin
                first_next   = win_first;
                last_next    = win_last;
                cur_next     = win_first;
                changed_next = 1'b0;
                mask_next    = 64'd0;
                top_next     = 1'b0;
                if (req_reg.cmd == CMD_FRAME && pkt_emit
                    && req_reg.sequence_req >= win_first)
                begin
                    if (off_pkt < 32'd64)       mask_next = 64'd1 << off_pkt[5:0];
                    else if (off_pkt == 32'd64) top_next  = 1'b1;
                end
            end
            ST_P_CHK:
            begin
                pmr_next = p_cl_cur;
                if (!p_hit)
                begin
                    cur_next     = at_end ? first_reg : cur_reg + 32'd1;
                    changed_next = at_end ? 1'b0 : changed_reg;
                end
            end
            ST_A_CHK:
            begin
                a_next = f_cl_cur;
            end
            ST_B_CHK:
            begin
                w_next = '0;
                if (fix_a)
                begin
                    dst_next      = a_reg;
                    dst_slot_next = cur_slot;
                    src_slot_next = prev_slot;
                    src_mask_next = f_cl_prev.wmask;
                end
                else if (fix_b)
                begin
                    dst_next      = f_cl_prev;
                    dst_slot_next = prev_slot;
                    src_slot_next = cur_slot;
                    src_mask_next = a_reg.wmask;
                end
                else
                begin
                    cur_next     = at_end ? first_reg : cur_reg + 32'd1;
                    changed_next = at_end ? 1'b0 : changed_reg;
                end
            end
            ST_X_WR:
            begin
                w_next = w_reg + WIDX_W'(1);
            end
            ST_X_META:
            begin
                cur_next     = at_end ? first_reg : cur_reg + 32'd1;
                changed_next = !at_end;
            end
            ST_E_CHK:
            begin
                if (f_cl_cur.present && !f_cl_cur.emitted)
                begin
                    if (off_cur < 32'd64)       mask_next = mask_reg | (64'd1 << off_cur[5:0]);
                    else if (off_cur == 32'd64) top_next  = 1'b1;
                end
                if (!at_end)
                begin
                    cur_next = cur_reg + 32'd1;
                end
            end
            default:
            begin
                w_next = w_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            changed_reg <= 1'b0;
            cur_reg     <= 32'd1;
            first_reg   <= 32'd1;
            last_reg    <= 32'd1;
            w_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            changed_reg <= changed_next;
            cur_reg     <= cur_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            w_reg       <= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        mask_reg     <= mask_next;
        top_reg      <= top_next;
        pmr_reg      <= pmr_next;
        a_reg        <= a_next;
        dst_reg      <= dst_next;
        dst_slot_reg <= dst_slot_next;
        src_slot_reg <= src_slot_next;
        src_mask_reg <= src_mask_next;
        rd_pres_reg  <= rd_pres_next;
        rd_use_reg   <= rd_use_next;
    end

    // --------------------------------------------------------------- assertions
    a_xor_slots_differ: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_X_WR) |-> (dst_slot_reg != src_slot_reg))
        else $error("rebuild target equals source slot");

    a_cur_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P_CHK || state_reg == ST_B_CHK || state_reg == ST_E_CHK)
        |-> (cur_reg >= first_reg && cur_reg <= last_reg))
        else $error("window cursor out of range");

    a_emit_needs_present: assert property (@(posedge clk) disable iff (!rst_n)
        (fm_port.we && state_reg != ST_CLEAR) |-> (fm_wdata.present || !fm_wdata.emitted))
        else $error("frame marked emitted while absent");

    a_rebuild_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_X_META) |-> ($past(state_reg) == ST_X_WR && $past(w_last)))
        else $error("rebuild ended early");

endmodule
